// File: hw/rtl/dijet_event_selector_assert.svh
// Assertion macros shared by the dijet selector modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef DIJET_EVENT_SELECTOR_ASSERT_SVH
`define DIJET_EVENT_SELECTOR_ASSERT_SVH

// Check that cons holds whenever ante holds, in the same cycle.
`define DSEL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dijet selector assertion failed");

// Check that cons holds in the cycle after ante holds.
`define DSEL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dijet selector assertion failed");

`endif

// File: hw/rtl/dsel_pkg.sv
`default_nettype none

package dsel_pkg;

	// Configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SUB_PT_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_TIME_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_GAP_MAX    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B2B_ANGLE_MIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_CUT_ENABLE = 3'd4;

	// Register reset values
	localparam logic [15:0] SUB_PT_MIN_RST      = 16'd768;
	localparam logic [10:0] LEAD_TIME_MAX_RST   = 11'd96;
	localparam logic [11:0] TIME_GAP_MAX_RST    = 12'd48;
	localparam logic [15:0] B2B_ANGLE_MIN_RST   = 16'd24576;
	localparam logic        TIME_CUT_ENABLE_RST = 1'b0;

	// Time held by an empty leader or sublead slot
	localparam logic signed [11:0] TIME_EMPTY = 12'sd2047;

	// Jet count saturates here
	localparam logic [1:0] JETS_FULL = 2'd2;

	typedef struct packed {
		logic        [15:0] pt;
		logic signed [15:0] angle;
		logic signed [11:0] tm;
		logic               last;
	} jet_t;

	typedef struct packed {
		logic [15:0] sub_pt_min;
		logic [10:0] lead_time_max;
		logic [11:0] time_gap_max;
		logic [15:0] b2b_angle_min;
		logic        time_cut_enable;
	} cfg_t;

	typedef struct packed {
		logic               seen_two;
		logic        [15:0] best_pt;
		logic signed [15:0] best_angle;
		logic signed [11:0] best_tm;
		logic        [15:0] second_pt;
		logic signed [15:0] second_angle;
		logic signed [11:0] second_tm;
	} summary_t;

	typedef struct packed {
		logic               is_dijet;
		logic        [15:0] lead_pt;
		logic        [15:0] sub_pt;
		logic signed [15:0] angle_gap;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/dsel_cfg.sv
`default_nettype none

module dsel_cfg
	import dsel_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Always take writes
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Write the addressed register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sub_pt_min      <= SUB_PT_MIN_RST;
			cfg_q.lead_time_max   <= LEAD_TIME_MAX_RST;
			cfg_q.time_gap_max    <= TIME_GAP_MAX_RST;
			cfg_q.b2b_angle_min   <= B2B_ANGLE_MIN_RST;
			cfg_q.time_cut_enable <= TIME_CUT_ENABLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SUB_PT_MIN: begin
					cfg_q.sub_pt_min <= cfg_data;
				end
				REG_LEAD_TIME_MAX: begin
					cfg_q.lead_time_max <= cfg_data[10:0];
				end
				REG_TIME_GAP_MAX: begin
					cfg_q.time_gap_max <= cfg_data[11:0];
				end
				REG_B2B_ANGLE_MIN: begin
					cfg_q.b2b_angle_min <= cfg_data;
				end
				REG_TIME_CUT_ENABLE: begin
					cfg_q.time_cut_enable <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dsel_track.sv
`default_nettype none

module dsel_track
	import dsel_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire jet_t jet,
	output summary_t  sum
);

	`include "dijet_event_selector_assert.svh"

	logic        [15:0] best_pt_q;
	logic signed [15:0] best_angle_q;
	logic signed [11:0] best_tm_q;
	logic        [15:0] second_pt_q;
	logic signed [15:0] second_angle_q;
	logic signed [11:0] second_tm_q;
	logic        [1:0]  jets_seen_q;

	logic        [15:0] best_pt_n;
	logic signed [15:0] best_angle_n;
	logic signed [11:0] best_tm_n;
	logic        [15:0] second_pt_n;
	logic signed [15:0] second_angle_n;
	logic signed [11:0] second_tm_n;
	logic        [1:0]  jets_seen_n;

	// Rank the incoming jet against the top two; a tie never displaces the jet it ties
	always_comb begin
		best_pt_n      = best_pt_q;
		best_angle_n   = best_angle_q;
		best_tm_n      = best_tm_q;
		second_pt_n    = second_pt_q;
		second_angle_n = second_angle_q;
		second_tm_n    = second_tm_q;
		if (jet.pt > best_pt_q) begin
			second_pt_n    = best_pt_q;
			second_angle_n = best_angle_q;
			second_tm_n    = best_tm_q;
			best_pt_n      = jet.pt;
			best_angle_n   = jet.angle;
			best_tm_n      = jet.tm;
		end else if (jet.pt > second_pt_q) begin
			second_pt_n    = jet.pt;
			second_angle_n = jet.angle;
			second_tm_n    = jet.tm;
		end
		jets_seen_n = (jets_seen_q == JETS_FULL) ? JETS_FULL : jets_seen_q + 2'd1;
	end

	// Present the updated event for the cut logic
	always_comb begin
		sum.seen_two     = (jets_seen_n == JETS_FULL);
		sum.best_pt      = best_pt_n;
		sum.best_angle   = best_angle_n;
		sum.best_tm      = best_tm_n;
		sum.second_pt    = second_pt_n;
		sum.second_angle = second_angle_n;
		sum.second_tm    = second_tm_n;
	end

	// Hold event state, clear it after the last jet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_pt_q      <= '0;
			best_angle_q   <= '0;
			best_tm_q      <= TIME_EMPTY;
			second_pt_q    <= '0;
			second_angle_q <= '0;
			second_tm_q    <= TIME_EMPTY;
			jets_seen_q    <= '0;
		end else if (adv) begin
			if (jet.last) begin
				best_pt_q      <= '0;
				best_angle_q   <= '0;
				best_tm_q      <= TIME_EMPTY;
				second_pt_q    <= '0;
				second_angle_q <= '0;
				second_tm_q    <= TIME_EMPTY;
				jets_seen_q    <= '0;
			end else begin
				best_pt_q      <= best_pt_n;
				best_angle_q   <= best_angle_n;
				best_tm_q      <= best_tm_n;
				second_pt_q    <= second_pt_n;
				second_angle_q <= second_angle_n;
				second_tm_q    <= second_tm_n;
				jets_seen_q    <= jets_seen_n;
			end
		end
	end

	// Sublead never outranks leader; count saturates
	`DSEL_ASSERT_NOW(a_rank_order, 1'b1, second_pt_q <= best_pt_q)
	`DSEL_ASSERT_NOW(a_count_sat, 1'b1, jets_seen_q <= JETS_FULL)
	// A last jet starts the next event empty
	`DSEL_ASSERT_NEXT(a_event_clear, adv && jet.last, jets_seen_q == 2'd0 && best_pt_q == 16'd0)

endmodule

`default_nettype wire

// File: hw/rtl/dsel_cuts.sv
`default_nettype none

module dsel_cuts
	import dsel_pkg::*;
(
	input  wire summary_t sum,
	input  wire cfg_t     cfg,
	output result_t       res
);

	logic signed [15:0] gap;
	logic        [16:0] gap_mag;
	logic        [11:0] lead_mag;
	logic signed [12:0] tdiff;
	logic        [12:0] tdiff_mag;
	logic               time_fail;
	logic               angle_ok;
	logic               pt_ok;

	// Wrap the azimuth gap to a half turn and take magnitudes
	always_comb begin
		gap       = sum.best_angle - sum.second_angle;
		gap_mag   = gap[15] ? (17'd0 - {gap[15], gap}) : {1'b0, gap};
		lead_mag  = sum.best_tm[11] ? (12'd0 - sum.best_tm) : sum.best_tm;
		tdiff     = {sum.best_tm[11], sum.best_tm} - {sum.second_tm[11], sum.second_tm};
		tdiff_mag = tdiff[12] ? (13'd0 - tdiff) : tdiff;
	end

	// Apply the cuts
	always_comb begin
		time_fail = cfg.time_cut_enable &&
			((lead_mag > {1'b0, cfg.lead_time_max}) ||
			 (tdiff_mag > {1'b0, cfg.time_gap_max}));
		angle_ok  = gap_mag > {1'b0, cfg.b2b_angle_min};
		pt_ok     = sum.second_pt >= cfg.sub_pt_min;
		res.is_dijet  = sum.seen_two && !time_fail && pt_ok && angle_ok;
		res.lead_pt   = sum.best_pt;
		res.sub_pt    = sum.second_pt;
		res.angle_gap = gap;
	end

endmodule

`default_nettype wire

// File: hw/rtl/dijet_event_selector.sv
`default_nettype none

// Dijet event selector. Jets enter one per cycle with last_jet on the final
// jet of an event; the block keeps the two highest-pt jets (a tie never
// displaces the leader) and, for each last jet, delivers one result: the
// dijet decision, leading and subleading pt and the wrapped azimuth gap.
// A jet is captured in the input register, and the top-two update plus
// all cuts are done in one pass into the result register, which offers a
// result once its last jet leaves the input register. Throughput is one jet
// per cycle; in_stall rises only while a last jet waits behind a result
// that downstream has not taken. Configuration writes are taken in any
// cycle (cfg_ready is always high) and should be made while no event is
// in flight.
module dijet_event_selector
	import dsel_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Jet input
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic        [15:0]    jet_pt,
	input  wire logic signed [15:0]    jet_angle,
	input  wire logic signed [11:0]    jet_time,
	input  wire logic                  last_jet,
	// Result output
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       is_dijet,
	output logic             [15:0]    lead_pt,
	output logic             [15:0]    sub_pt,
	output logic signed      [15:0]    angle_gap,
	// Configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	`include "dijet_event_selector_assert.svh"

	cfg_t     cfg;
	jet_t     jet_s1;
	logic     valid_s1;
	logic     adv_s1;
	logic     out_free;
	summary_t sum;
	result_t  res;
	result_t  res_q;
	logic     out_valid_q;

	dsel_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stall only a last jet that has nowhere to put its result
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && jet_s1.last && !out_free;
	assign adv_s1   = valid_s1 && !in_stall;

	// Capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			jet_s1.pt    <= jet_pt;
			jet_s1.angle <= jet_angle;
			jet_s1.tm    <= jet_time;
			jet_s1.last  <= last_jet;
		end
	end

	dsel_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv_s1),
		.jet    (jet_s1),
		.sum    (sum)
	);

	dsel_cuts u_cuts (
		.sum (sum),
		.cfg (cfg),
		.res (res)
	);

	// Load the result register on a last jet, drain it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && jet_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && jet_s1.last) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign is_dijet  = res_q.is_dijet;
	assign lead_pt   = res_q.lead_pt;
	assign sub_pt    = res_q.sub_pt;
	assign angle_gap = res_q.angle_gap;

	// A last jet that advances shows up as a result
	`DSEL_ASSERT_NEXT(a_last_to_out, adv_s1 && jet_s1.last, out_valid_q)
	// Input stalls only behind a blocked result
	`DSEL_ASSERT_NOW(a_stall_cause, in_stall, valid_s1 && jet_s1.last && out_valid_q && out_stall)
	// Reported sublead never exceeds the leader
	`DSEL_ASSERT_NOW(a_out_order, out_valid_q, res_q.sub_pt <= res_q.lead_pt)

endmodule

`default_nettype wire
